// ===== src/adll_pkg.sv =====
// Shared constants, opcodes, status codes and control types for the
// array doubly linked list engine. No dependencies.
package adll_pkg;

	// default pool geometry
	localparam int ENTRIES_DEF      = 64;
	localparam int PAYLOAD_BITS_DEF = 32;

	// slots examined per step of the free slot finder
	localparam int FIND_GROUP = 8;

	// fixed field widths
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;

	// request opcodes
	localparam logic [OP_W-1:0] OP_ADD_FIRST  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_AFTER  = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD_LAST   = 3'd2;
	localparam logic [OP_W-1:0] OP_MOVE_FIRST = 3'd3;
	localparam logic [OP_W-1:0] OP_MOVE_AFTER = 3'd4;
	localparam logic [OP_W-1:0] OP_MOVE_LAST  = 3'd5;
	localparam logic [OP_W-1:0] OP_READ_SLOT  = 3'd6;
	localparam logic [OP_W-1:0] OP_NOP        = 3'd7;

	// response status codes
	localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_LISTED = 2'd2;

	// step controls for the free slot finder
	typedef struct packed {
		logic find_group;
		logic find_bit;
	} find_ctl_t;

endpackage

// ===== src/adll_ram.sv =====
// Generic single write, single read RAM with registered read data.
// No dependencies.
module adll_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/adll_free_find.sv =====
// Two step lowest free slot finder: first the lowest group with a free slot,
// then the lowest free slot inside that group. Depends on adll_pkg.
module adll_free_find #(
	parameter int ENTRIES = adll_pkg::ENTRIES_DEF
) (
	input  logic                       clk,
	input  adll_pkg::find_ctl_t        ctl,
	input  logic [ENTRIES-1:0]         in_use,
	output logic [$clog2(ENTRIES)-1:0] free_slot
);

	localparam int GROUP   = adll_pkg::FIND_GROUP;
	localparam int NGROUPS = (ENTRIES + GROUP - 1) / GROUP;
	localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
	localparam int BIT_W   = $clog2(GROUP);
	localparam int SLOT_W  = $clog2(ENTRIES);

	logic [NGROUPS*GROUP-1:0] padded;
	logic [NGROUPS-1:0]       group_full;
	logic [GRP_W-1:0]         grp_pick;
	logic [GRP_W-1:0]         grp_q;
	logic [GROUP-1:0]         word;
	logic [BIT_W-1:0]         bit_pick;

	// slots past the end of the pool count as taken
	always_comb begin
		padded = '1;
		padded[ENTRIES-1:0] = in_use;
	end

	// per group full flags and lowest non-full group
	always_comb begin
		grp_pick = '0;
		for (int g = 0; g < NGROUPS; g++) begin
			group_full[g] = &padded[g*GROUP +: GROUP];
		end
		for (int g = NGROUPS - 1; g >= 0; g--) begin
			if (!group_full[g]) begin
				grp_pick = GRP_W'(g);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.find_group) begin
			grp_q <= grp_pick;
		end
	end

	// lowest free bit inside the chosen group
	always_comb begin
		word = padded[int'(grp_q)*GROUP +: GROUP];
		bit_pick = '0;
		for (int b = GROUP - 1; b >= 0; b--) begin
			if (!word[b]) begin
				bit_pick = BIT_W'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.find_bit) begin
			free_slot <= SLOT_W'({grp_q, bit_pick});
		end
	end

endmodule

// ===== src/array_doubly_linked_list_engine_unit.sv =====
// Top level of the array doubly linked list engine: sequencer, list state and
// link memories. Depends on adll_pkg, adll_ram and adll_free_find.
//
// Usage:
//   A request (req_valid/req_ready) carries opcode, target_slot, anchor_slot
//   and payload. Each request gives exactly one response (rsp_valid/rsp_ready)
//   with status, used_slot, head_index, tail_index, element_count and, for a
//   successful read, read_next, read_prev and read_payload (zero otherwise).
//   Empty head, tail and missing links read as ENTRIES.
//   req_ready is high only while the sequencer is idle. A request steps
//   through the link reads (ST_RD, ST_RD2), evaluation (ST_EVAL), the link
//   writes (ST_WR) and the response load (ST_OUT); a new request is taken
//   only after the previous one has been loaded into the output register.
//   The single write port of each link memory takes up to three link
//   updates per request, written one after another in ST_WR.
//   A stalled response is held in the output register; the next request may
//   be accepted meanwhile and waits in its load cycle until the response is
//   taken.
//   Reset empties the list (all slots free, head and tail none, count zero)
//   and clears rsp_valid; no memory clearing pass is needed.
module array_doubly_linked_list_engine_unit #(
	parameter int ENTRIES      = adll_pkg::ENTRIES_DEF,
	parameter int PAYLOAD_BITS = adll_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [adll_pkg::OP_W-1:0]         opcode,
	input  logic [$clog2(ENTRIES)-1:0]        target_slot,
	input  logic [$clog2(ENTRIES)-1:0]        anchor_slot,
	input  logic [PAYLOAD_BITS-1:0]           payload,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [adll_pkg::STATUS_W-1:0]     status,
	output logic [$clog2(ENTRIES)-1:0]        used_slot,
	output logic [$clog2(ENTRIES+1)-1:0]      head_index,
	output logic [$clog2(ENTRIES+1)-1:0]      tail_index,
	output logic [$clog2(ENTRIES+1)-1:0]      element_count,
	output logic [$clog2(ENTRIES+1)-1:0]      read_next,
	output logic [$clog2(ENTRIES+1)-1:0]      read_prev,
	output logic [PAYLOAD_BITS-1:0]           read_payload
);

	localparam int SLOT_W   = $clog2(ENTRIES);
	localparam int LINK_W   = $clog2(ENTRIES + 1);
	localparam int WR_SLOTS = 3;
	localparam int WCNT_W   = 2;
	localparam logic [LINK_W-1:0] NONE = LINK_W'(ENTRIES);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_RD2  = 3'd2;
	localparam logic [2:0] ST_EVAL = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]                    state_q;
	logic [WCNT_W-1:0]             wcnt_q;

	// list state
	logic [ENTRIES-1:0]            in_use_q;
	logic [LINK_W-1:0]             head_q;
	logic [LINK_W-1:0]             tail_q;
	logic [LINK_W-1:0]             count_q;

	// latched request
	logic [adll_pkg::OP_W-1:0]     op_q;
	logic [SLOT_W-1:0]             tgt_q;
	logic [SLOT_W-1:0]             anc_q;
	logic [PAYLOAD_BITS-1:0]       pay_q;

	// link words read for this request
	logic [LINK_W-1:0]             nx_q;
	logic [LINK_W-1:0]             px_q;
	logic [PAYLOAD_BITS-1:0]       rpay_q;

	// pending link writes
	logic                          wn_en_q   [WR_SLOTS];
	logic [SLOT_W-1:0]             wn_addr_q [WR_SLOTS];
	logic [LINK_W-1:0]             wn_data_q [WR_SLOTS];
	logic                          wp_en_q   [WR_SLOTS];
	logic [SLOT_W-1:0]             wp_addr_q [WR_SLOTS];
	logic [LINK_W-1:0]             wp_data_q [WR_SLOTS];

	// held result of the evaluate step
	logic [adll_pkg::STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]             res_used_q;
	logic [LINK_W-1:0]             res_next_q;
	logic [LINK_W-1:0]             res_prev_q;
	logic [PAYLOAD_BITS-1:0]       res_pay_q;

	// output register
	logic                          rsp_valid_q;
	logic [adll_pkg::STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]             used_q;
	logic [LINK_W-1:0]             head_out_q;
	logic [LINK_W-1:0]             tail_out_q;
	logic [LINK_W-1:0]             count_out_q;
	logic [LINK_W-1:0]             rnext_out_q;
	logic [LINK_W-1:0]             rprev_out_q;
	logic [PAYLOAD_BITS-1:0]       rpay_out_q;

	// memory ports
	logic                          nl_we;
	logic [SLOT_W-1:0]             nl_waddr;
	logic [LINK_W-1:0]             nl_wdata;
	logic [SLOT_W-1:0]             nl_raddr;
	logic [LINK_W-1:0]             nl_rdata;
	logic                          pl_we;
	logic [SLOT_W-1:0]             pl_waddr;
	logic [LINK_W-1:0]             pl_wdata;
	logic [LINK_W-1:0]             pl_rdata;
	logic                          pay_we;
	logic [PAYLOAD_BITS-1:0]       pay_rdata;

	// finder
	adll_pkg::find_ctl_t           find_ctl;
	logic [SLOT_W-1:0]             free_slot;

	// evaluate step
	logic [LINK_W-1:0]             x_l;
	logic [LINK_W-1:0]             a_add;
	logic [LINK_W-1:0]             a_mv;
	logic                          is_add;
	logic                          front;
	logic [LINK_W-1:0]             h_d;
	logic [LINK_W-1:0]             t_d;
	logic [LINK_W-1:0]             c_d;
	logic [adll_pkg::STATUS_W-1:0] st_d;
	logic [SLOT_W-1:0]             used_d;
	logic [LINK_W-1:0]             rn_d;
	logic [LINK_W-1:0]             rp_d;
	logic [PAYLOAD_BITS-1:0]       rpay_d;
	logic                          add_ok;
	logic                          wn_en_d   [WR_SLOTS];
	logic [LINK_W-1:0]             wn_addr_d [WR_SLOTS];
	logic [LINK_W-1:0]             wn_data_d [WR_SLOTS];
	logic                          wp_en_d   [WR_SLOTS];
	logic [LINK_W-1:0]             wp_addr_d [WR_SLOTS];
	logic [LINK_W-1:0]             wp_data_d [WR_SLOTS];

	// a slot is listed when it is inside the pool and in use
	function automatic logic listed(input logic [LINK_W-1:0] s);
		listed = (s < LINK_W'(ENTRIES)) && in_use_q[s[SLOT_W-1:0]];
	endfunction

	// operand selection
	always_comb begin
		x_l    = LINK_W'(tgt_q);
		is_add = (op_q == adll_pkg::OP_ADD_FIRST) || (op_q == adll_pkg::OP_ADD_AFTER) ||
		         (op_q == adll_pkg::OP_ADD_LAST);
		front  = (op_q == adll_pkg::OP_ADD_FIRST) ||
		         ((op_q == adll_pkg::OP_ADD_LAST) && (head_q == NONE));
		a_add  = (op_q == adll_pkg::OP_ADD_LAST) ? tail_q : LINK_W'(anc_q);
		a_mv   = (op_q == adll_pkg::OP_MOVE_LAST) ? tail_q : LINK_W'(anc_q);
	end

	// free slot finder runs during the read states ST_RD and ST_RD2
	always_comb begin
		find_ctl.find_group = (state_q == ST_RD);
		find_ctl.find_bit   = (state_q == ST_RD2);
	end

	adll_free_find #(
		.ENTRIES (ENTRIES)
	) u_find (
		.clk       (clk),
		.ctl       (find_ctl),
		.in_use    (in_use_q),
		.free_slot (free_slot)
	);

	// link memory addressing: first read the target or add anchor, then the
	// move anchor; writes drain the pending list one entry per cycle
	always_comb begin
		nl_raddr = tgt_q;
		if (state_q == ST_RD && is_add) begin
			nl_raddr = a_add[SLOT_W-1:0];
		end else if (state_q == ST_RD2) begin
			nl_raddr = a_mv[SLOT_W-1:0];
		end
		nl_we    = (state_q == ST_WR) && wn_en_q[wcnt_q];
		nl_waddr = wn_addr_q[wcnt_q];
		nl_wdata = wn_data_q[wcnt_q];
		pl_we    = (state_q == ST_WR) && wp_en_q[wcnt_q];
		pl_waddr = wp_addr_q[wcnt_q];
		pl_wdata = wp_data_q[wcnt_q];
		pay_we   = (state_q == ST_EVAL) && add_ok;
	end

	adll_ram #(
		.WIDTH (LINK_W),
		.DEPTH (ENTRIES)
	) u_next_ram (
		.clk   (clk),
		.we    (nl_we),
		.waddr (nl_waddr),
		.wdata (nl_wdata),
		.raddr (nl_raddr),
		.rdata (nl_rdata)
	);

	adll_ram #(
		.WIDTH (LINK_W),
		.DEPTH (ENTRIES)
	) u_prev_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (pl_waddr),
		.wdata (pl_wdata),
		.raddr (tgt_q),
		.rdata (pl_rdata)
	);

	adll_ram #(
		.WIDTH (PAYLOAD_BITS),
		.DEPTH (ENTRIES)
	) u_pay_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr (free_slot),
		.wdata (pay_q),
		.raddr (tgt_q),
		.rdata (pay_rdata)
	);

	// evaluate: checks, new head/tail/count and the list of link writes
	always_comb begin
		h_d    = head_q;
		t_d    = tail_q;
		c_d    = count_q;
		st_d   = adll_pkg::STATUS_OK;
		used_d = '0;
		rn_d   = '0;
		rp_d   = '0;
		rpay_d = '0;
		add_ok = 1'b0;
		for (int k = 0; k < WR_SLOTS; k++) begin
			wn_en_d[k]   = 1'b0;
			wn_addr_d[k] = '0;
			wn_data_d[k] = '0;
			wp_en_d[k]   = 1'b0;
			wp_addr_d[k] = '0;
			wp_data_d[k] = '0;
		end
		case (op_q)
			adll_pkg::OP_ADD_FIRST, adll_pkg::OP_ADD_AFTER, adll_pkg::OP_ADD_LAST: begin
				if (count_q >= LINK_W'(ENTRIES)) begin
					st_d = adll_pkg::STATUS_FULL;
				end else if (!front && !listed(a_add)) begin
					st_d = adll_pkg::STATUS_NOT_LISTED;
				end else begin
					add_ok = 1'b1;
					used_d = free_slot;
					c_d    = count_q + LINK_W'(1);
					if (front) begin
						// new slot in front of the old head
						wp_en_d[0] = 1'b1; wp_addr_d[0] = LINK_W'(free_slot); wp_data_d[0] = NONE;
						wn_en_d[0] = 1'b1; wn_addr_d[0] = LINK_W'(free_slot); wn_data_d[0] = head_q;
						if (head_q == NONE) begin
							t_d = LINK_W'(free_slot);
						end else begin
							wp_en_d[1] = 1'b1; wp_addr_d[1] = head_q;
							wp_data_d[1] = LINK_W'(free_slot);
						end
						h_d = LINK_W'(free_slot);
					end else begin
						// new slot between the anchor and its successor
						wp_en_d[0] = 1'b1; wp_addr_d[0] = LINK_W'(free_slot); wp_data_d[0] = a_add;
						wn_en_d[0] = 1'b1; wn_addr_d[0] = LINK_W'(free_slot); wn_data_d[0] = nx_q;
						wn_en_d[1] = 1'b1; wn_addr_d[1] = a_add; wn_data_d[1] = LINK_W'(free_slot);
						if (nx_q == NONE) begin
							t_d = LINK_W'(free_slot);
						end else begin
							wp_en_d[1] = 1'b1; wp_addr_d[1] = nx_q;
							wp_data_d[1] = LINK_W'(free_slot);
						end
					end
				end
			end
			adll_pkg::OP_MOVE_FIRST: begin
				if (!listed(x_l)) begin
					st_d = adll_pkg::STATUS_NOT_LISTED;
				end else if (x_l != head_q) begin
					// unlink the target
					if (px_q == NONE) begin
						h_d = nx_q;
					end else begin
						wn_en_d[0] = 1'b1; wn_addr_d[0] = px_q; wn_data_d[0] = nx_q;
					end
					if (nx_q == NONE) begin
						t_d = px_q;
					end else begin
						wp_en_d[0] = 1'b1; wp_addr_d[0] = nx_q; wp_data_d[0] = px_q;
					end
					// relink at the front
					wp_en_d[1] = 1'b1; wp_addr_d[1] = x_l; wp_data_d[1] = NONE;
					wn_en_d[1] = 1'b1; wn_addr_d[1] = x_l; wn_data_d[1] = h_d;
					if (h_d == NONE) begin
						t_d = x_l;
					end else begin
						wp_en_d[2] = 1'b1; wp_addr_d[2] = h_d; wp_data_d[2] = x_l;
					end
					h_d = x_l;
				end
			end
			adll_pkg::OP_MOVE_AFTER, adll_pkg::OP_MOVE_LAST: begin
				if (!listed(x_l) || !listed(a_mv)) begin
					st_d = adll_pkg::STATUS_NOT_LISTED;
				end else if ((a_mv != x_l) && (a_mv != px_q)) begin
					// unlink the target
					if (px_q == NONE) begin
						h_d = nx_q;
					end else begin
						wn_en_d[0] = 1'b1; wn_addr_d[0] = px_q; wn_data_d[0] = nx_q;
					end
					if (nx_q == NONE) begin
						t_d = px_q;
					end else begin
						wp_en_d[0] = 1'b1; wp_addr_d[0] = nx_q; wp_data_d[0] = px_q;
					end
					// relink after the anchor; its successor is unchanged by the unlink
					wp_en_d[1] = 1'b1; wp_addr_d[1] = x_l; wp_data_d[1] = a_mv;
					wn_en_d[1] = 1'b1; wn_addr_d[1] = x_l; wn_data_d[1] = nl_rdata;
					wn_en_d[2] = 1'b1; wn_addr_d[2] = a_mv; wn_data_d[2] = x_l;
					if (nl_rdata == NONE) begin
						t_d = x_l;
					end else begin
						wp_en_d[2] = 1'b1; wp_addr_d[2] = nl_rdata; wp_data_d[2] = x_l;
					end
				end
			end
			adll_pkg::OP_READ_SLOT: begin
				if (!listed(x_l)) begin
					st_d = adll_pkg::STATUS_NOT_LISTED;
				end else begin
					used_d = tgt_q;
					rn_d   = nx_q;
					rp_d   = px_q;
					rpay_d = rpay_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and list state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wcnt_q      <= '0;
			in_use_q    <= '0;
			head_q      <= NONE;
			tail_q      <= NONE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// response valid: set on load, cleared when taken
			if (state_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					head_q  <= h_d;
					tail_q  <= t_d;
					count_q <= c_d;
					if (add_ok) begin
						in_use_q[free_slot] <= 1'b1;
					end
					wcnt_q  <= '0;
					state_q <= ST_WR;
				end
				ST_WR: begin
					wcnt_q <= wcnt_q + WCNT_W'(1);
					if (wcnt_q == WCNT_W'(WR_SLOTS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request latch, read capture, pending writes and result data
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			op_q  <= opcode;
			tgt_q <= target_slot;
			anc_q <= anchor_slot;
			pay_q <= payload;
		end
		if (state_q == ST_RD2) begin
			nx_q   <= nl_rdata;
			px_q   <= pl_rdata;
			rpay_q <= pay_rdata;
		end
		if (state_q == ST_EVAL) begin
			for (int k = 0; k < WR_SLOTS; k++) begin
				wn_en_q[k]   <= wn_en_d[k];
				wn_addr_q[k] <= wn_addr_d[k][SLOT_W-1:0];
				wn_data_q[k] <= wn_data_d[k];
				wp_en_q[k]   <= wp_en_d[k];
				wp_addr_q[k] <= wp_addr_d[k][SLOT_W-1:0];
				wp_data_q[k] <= wp_data_d[k];
			end
			res_status_q <= st_d;
			res_used_q   <= used_d;
			res_next_q   <= rn_d;
			res_prev_q   <= rp_d;
			res_pay_q    <= rpay_d;
		end
		if (state_q == ST_OUT && (!rsp_valid_q || rsp_ready)) begin
			status_q    <= res_status_q;
			used_q      <= res_used_q;
			head_out_q  <= head_q;
			tail_out_q  <= tail_q;
			count_out_q <= count_q;
			rnext_out_q <= res_next_q;
			rprev_out_q <= res_prev_q;
			rpay_out_q  <= res_pay_q;
		end
	end

	// ports
	assign req_ready     = (state_q == ST_IDLE);
	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign used_slot     = used_q;
	assign head_index    = head_out_q;
	assign tail_index    = tail_out_q;
	assign element_count = count_out_q;
	assign read_next     = rnext_out_q;
	assign read_prev     = rprev_out_q;
	assign read_payload  = rpay_out_q;

endmodule
